@@ hdl/udpq_pkg.sv @@
// shared types and constants for the udp port demultiplexer
package udpq_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] port_number;
    logic [12:0] frame_length;
    logic [15:0] ether_type;
    logic [3:0]  ip_version_nibble;
    logic [31:0] dest_ip_address;
    logic [31:0] source_ip_address;
    logic [15:0] source_port_number;
    logic [15:0] udp_length;
    logic [15:0] buffer_handle;
    logic [12:0] max_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic [12:0] payload_length;
    logic [31:0] out_source_ip;
    logic [15:0] out_source_port;
    logic        handle_valid;
    logic        last_result;
  } out_item_t;

  localparam logic [1:0] OP_BIND    = 2'd0;
  localparam logic [1:0] OP_UNBIND  = 2'd1;
  localparam logic [1:0] OP_DELIVER = 2'd2;
  localparam logic [1:0] OP_RECEIVE = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TABLE_FULL = 3'd1;
  localparam logic [2:0] ST_NOT_BOUND  = 3'd2;
  localparam logic [2:0] ST_MALFORMED  = 3'd3;
  localparam logic [2:0] ST_NOT_LOCAL  = 3'd4;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd5;
  localparam logic [2:0] ST_EMPTY      = 3'd6;
  localparam logic [2:0] ST_ARP        = 3'd7;

  localparam logic [15:0] TYPE_IPV4    = 16'h0800;
  localparam logic [15:0] TYPE_ARP     = 16'h0806;
  localparam logic [12:0] LEN_ARP_MIN  = 13'd42;
  localparam logic [12:0] LEN_IP_MIN   = 13'd34;
  localparam logic [12:0] LEN_UDP_MIN  = 13'd42;
  localparam logic [15:0] UDP_HDR      = 16'd8;
  localparam logic [12:0] RX_LIMIT     = 13'd4096;
  localparam logic [31:0] LOCAL_IP_RST = 32'd167772687;

  // result of the port lookup
  typedef struct packed {
    logic       hit;
    logic       free_found;
    logic [7:0] hit_slot;
    logic [7:0] free_slot;
  } lookup_t;

endpackage

@@ hdl/udp_port_demux_queue_top.sv @@
// udp port demultiplexer top: sequencer, queue pointers and result register
// one transaction at a time: lookup, pointer/memory access, then the result.
// the result is registered; a receive, and an unbind of a non-empty queue, first
// read the descriptor memory. a new input is taken only after the previous
// result has been accepted. unbind with n queued packets gives n handles, one
// after another, each once the previous one is accepted, via the single read port.
// reset (synchronous, active high) clears all bindings and queue pointers
// and sets the local ip to 10.0.2.15; descriptor memory is not cleared.
module udp_port_demux_queue_top #(
  parameter int PORT_SLOTS  = 16,
  parameter int QUEUE_DEPTH = 8,
  parameter int MAX_FRAME   = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  udpq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output udpq_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);
  import udpq_pkg::*;

  localparam int SIW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH+1);
  localparam int ENT = PORT_SLOTS * QUEUE_DEPTH;
  localparam int EW  = (ENT > 1) ? $clog2(ENT) : 1;
  localparam logic [12:0] MAXF = 13'((MAX_FRAME > 8191) ? 8191 : MAX_FRAME);
  localparam logic        MAXF_BIG = (MAX_FRAME > 8191);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_FLSH = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]    state;
  in_item_t      item;
  logic [31:0]   host_ip;
  lookup_t       lookup;
  logic [QW-1:0] head [PORT_SLOTS];
  logic [CW-1:0] count [PORT_SLOTS];
  logic [SIW-1:0] slot, rd_slot;
  logic [QW-1:0] idx;
  logic [CW-1:0] left;
  logic          bind_en, unbind_en;
  logic          we;
  logic [EW-1:0] waddr, raddr;
  logic [79:0]   wdata, rdata;
  logic [15:0]   plen16;
  logic [12:0]   plen;
  logic [QW-1:0] cur_head, tail;
  logic [CW-1:0] cur_cnt;
  logic [QW:0]   tail_sum;
  logic          flen_bad;
  logic [2:0]    exec_st;
  logic          exec_hv;
  logic          exec_read;
  out_item_t     out_next;

  assign in_ready  = (state == S_IDLE) && !rst;
  assign cfg_ready = (state == S_IDLE);

  udpq_slot_table #(.PORT_SLOTS(PORT_SLOTS)) u_tab (
    .clk, .rst, .port(item.port_number), .bind_en, .unbind_en,
    .wr_slot(slot), .lookup
  );

  udpq_entry_mem #(.ENTRIES(ENT)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  function automatic logic [QW-1:0] inc_idx(input logic [QW-1:0] v);
    if (32'(v) + 1 >= QUEUE_DEPTH) return '0;
    return v + QW'(1);
  endfunction

  // pointer view of the looked-up slot
  always_comb begin
    cur_head = head[lookup.hit_slot[SIW-1:0]];
    cur_cnt  = count[lookup.hit_slot[SIW-1:0]];
    tail_sum = {1'b0, cur_head} + (QW+1)'(cur_cnt);
    if (32'(tail_sum) >= QUEUE_DEPTH) tail = QW'(32'(tail_sum) - QUEUE_DEPTH);
    else tail = tail_sum[QW-1:0];
    flen_bad = MAXF_BIG ? 1'b0 : (item.frame_length > MAXF);
  end

  // outcome of the transaction in the exec state
  always_comb begin
    exec_st = ST_OK;
    exec_hv = 1'b0;
    exec_read = 1'b0;
    unique case (item.opcode)
      OP_BIND: begin
        if (!lookup.hit && !lookup.free_found) exec_st = ST_TABLE_FULL;
      end
      OP_UNBIND: begin
        if (!lookup.hit) exec_st = ST_NOT_BOUND;
        else exec_read = (cur_cnt != '0);
      end
      OP_DELIVER: begin
        if (flen_bad) exec_st = ST_MALFORMED;
        else if (item.ether_type == TYPE_ARP && item.frame_length >= LEN_ARP_MIN)
          exec_st = ST_ARP;
        else if (item.ether_type != TYPE_IPV4 || item.frame_length < LEN_IP_MIN)
          exec_st = ST_MALFORMED;
        else if (item.ip_version_nibble != 4'd4) exec_st = ST_MALFORMED;
        else if (item.dest_ip_address != host_ip) exec_st = ST_NOT_LOCAL;
        else if (item.frame_length < LEN_UDP_MIN) exec_st = ST_MALFORMED;
        else if (!lookup.hit) exec_st = ST_NOT_BOUND;
        else if (32'(cur_cnt) >= QUEUE_DEPTH) exec_st = ST_QUEUE_FULL;
        exec_hv = (exec_st != ST_OK);
      end
      default: begin
        if (!lookup.hit) exec_st = ST_NOT_BOUND;
        else if (item.max_length > RX_LIMIT) exec_st = ST_MALFORMED;
        else if (cur_cnt == '0) exec_st = ST_EMPTY;
        else exec_read = 1'b1;
      end
    endcase
  end

  // exec-state strobes
  always_comb begin
    bind_en = 1'b0; unbind_en = 1'b0; we = 1'b0;
    slot = lookup.hit_slot[SIW-1:0];
    if (state == S_EXEC) begin
      unique case (item.opcode)
        OP_BIND: begin
          slot = lookup.free_slot[SIW-1:0];
          bind_en = !lookup.hit && lookup.free_found;
        end
        OP_UNBIND: unbind_en = lookup.hit;
        OP_DELIVER: we = (exec_st == ST_OK);
        default: ;
      endcase
    end
  end

  assign waddr = EW'(32'(lookup.hit_slot[SIW-1:0]) * QUEUE_DEPTH + 32'(tail));
  assign wdata = {item.buffer_handle, item.udp_length, item.source_ip_address,
                  item.source_port_number};
  assign raddr = EW'(32'(rd_slot) * QUEUE_DEPTH + 32'(idx));

  // payload length from stored udp length
  always_comb begin
    plen16 = (rdata[63:48] > UDP_HDR) ? rdata[63:48] - UDP_HDR : 16'd0;
    plen = (plen16 > 16'(item.max_length)) ? item.max_length : plen16[12:0];
  end

  // next result transaction
  always_comb begin
    out_next = '0;
    out_next.last_result = 1'b1;
    if (state == S_FLSH) begin
      out_next.out_handle = rdata[79:64];
      out_next.handle_valid = 1'b1;
      if (item.opcode == OP_RECEIVE) begin
        out_next.payload_length = plen;
        out_next.out_source_ip = rdata[47:16];
        out_next.out_source_port = rdata[15:0];
      end else begin
        out_next.last_result = (left == CW'(1));
      end
    end else begin
      out_next.status = exec_st;
      if (exec_hv) begin
        out_next.out_handle = item.buffer_handle;
        out_next.handle_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) host_ip <= LOCAL_IP_RST;
    else if (cfg_valid && cfg_ready) host_ip <= cfg_data;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < PORT_SLOTS; i++) begin
        head[i] <= '0;
        count[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          item <= in_data;
          state <= S_LOOK;
        end
        S_LOOK: state <= S_EXEC;
        S_EXEC: begin
          out_data <= out_next;
          idx <= cur_head;
          left <= cur_cnt;
          rd_slot <= lookup.hit_slot[SIW-1:0];
          if (exec_read) state <= S_READ;
          else state <= S_OUT;
          unique case (item.opcode)
            OP_BIND: begin
              if (bind_en) begin
                head[slot] <= '0;
                count[slot] <= '0;
              end
            end
            OP_UNBIND: begin
              if (unbind_en) begin
                head[slot] <= '0;
                count[slot] <= '0;
              end
            end
            OP_DELIVER: begin
              if (we) count[slot] <= cur_cnt + CW'(1);
            end
            default: begin
              if (exec_read) begin
                head[slot] <= inc_idx(cur_head);
                count[slot] <= cur_cnt - CW'(1);
              end
            end
          endcase
        end
        S_READ: state <= S_FLSH;
        S_FLSH: begin
          // memory data for idx now in rdata
          out_data <= out_next;
          if (item.opcode != OP_RECEIVE) begin
            left <= left - CW'(1);
            idx <= inc_idx(idx);
          end
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            if (out_data.last_result) state <= S_IDLE;
            else state <= S_READ;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/udpq_slot_table.sv @@
// binding table: slot valid bits and bound port numbers, with lookup
module udpq_slot_table #(
  parameter int PORT_SLOTS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [15:0]              port,
  input  logic                     bind_en,
  input  logic                     unbind_en,
  input  logic [((PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1)-1:0] wr_slot,
  output udpq_pkg::lookup_t        lookup
);
  import udpq_pkg::*;

  logic [PORT_SLOTS-1:0] in_use;
  logic [15:0]           slot_port [PORT_SLOTS];
  lookup_t               lookup_next;

  // registered match and first-free search
  always_comb begin
    lookup_next = '0;
    for (int i = PORT_SLOTS-1; i >= 0; i--) begin
      if (in_use[i] && slot_port[i] == port) begin
        lookup_next.hit = 1'b1;
        lookup_next.hit_slot = 8'(i);
      end
      if (!in_use[i]) begin
        lookup_next.free_found = 1'b1;
        lookup_next.free_slot = 8'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    lookup <= lookup_next;
    if (bind_en) slot_port[wr_slot] <= port;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (bind_en) begin
      in_use[wr_slot] <= 1'b1;
    end else if (unbind_en) begin
      in_use[wr_slot] <= 1'b0;
    end
  end
endmodule

@@ hdl/udpq_entry_mem.sv @@
// packet descriptor memory, one write and one registered read port
module udpq_entry_mem #(
  parameter int ENTRIES = 128
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  logic [79:0]                wdata,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output logic [79:0]                rdata
);
  logic [79:0] mem [ENTRIES];

  // synchronous write and read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
